@@ rtl/div32_pkg.sv @@
// types, constants and the shared restoring step of the 32-by-16 divider pipeline
package div32_pkg;

    localparam int QUOT_BITS       = 16;
    localparam int STEPS_PER_STAGE = 2;
    localparam int NUM_ITER_STAGES = QUOT_BITS / STEPS_PER_STAGE;

    // largest signed quotient magnitudes for a positive and a negative result
    localparam logic [15:0] Q_POS_MAX = 16'h7fff;
    localparam logic [15:0] Q_NEG_MAX = 16'h8000;

    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    typedef struct packed {
        logic [31:0] acc;          // partial remainder above, dividend bits / quotient below
        logic [15:0] divisor_mag;
        logic [31:0] dividend;     // original register value for pass-through
        logic        signed_op;
        logic        q_neg;
        logic        r_neg;
        logic        pre_ovf;
        logic        trap;
        logic        old_n;
        logic        old_z;
        logic        old_c;
    } stage_t;

    typedef struct packed {
        logic [31:0] new_register;
        logic        register_written;
        logic        flag_n;
        logic        flag_z;
        logic        flag_v;
        logic        flag_c;
        logic        divide_trap;
    } result_t;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic logic [31:0] div_step(logic [31:0] acc, logic [15:0] d);
        logic [16:0] rem;
        logic [17:0] diff;
        logic        q;
        rem  = {acc[31:16], acc[15]};
        diff = {1'b0, rem} - {2'b00, d};
        q    = ~diff[17];
        div_step = {(q ? diff[15:0] : rem[15:0]), acc[14:0], q};
    endfunction

endpackage

@@ rtl/divide_32_by_16_with_flags.sv @@
// pipelined 32-by-16 unsigned/signed divide with condition flags
//
//  channel   signals                                              direction
//  input     in_valid, in_ready, operation, dividend, divisor,    in (ready out)
//            old_n, old_z, old_c
//  output    out_valid, out_ready, new_register, register_written, out (ready in)
//            flag_n, flag_z, flag_v, flag_c, divide_trap
//
// ten register stages: one setup stage for magnitudes and the overflow pre-check,
// eight stages of two restoring steps each, one result stage whose valid bit drives out_valid.
// one transaction is accepted per cycle unless a stall at the output has backed up to the input;
// clock rate is set by two chained 17-bit subtracts.
// rst_n clears only the valid bits; payload registers are not reset.
// a stall at the output holds each full stage with no empty stage after it; stages behind a gap still move.
module divide_32_by_16_with_flags
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    input  logic        old_n,
    input  logic        old_z,
    input  logic        old_c,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] new_register,
    output logic        register_written,
    output logic        flag_n,
    output logic        flag_z,
    output logic        flag_v,
    output logic        flag_c,
    output logic        divide_trap
);

    localparam int NI   = div32_pkg::NUM_ITER_STAGES;
    localparam int LAST = NI + 1;   // index of the result stage

    div32_pkg::stage_t  stage_reg  [0:NI];
    div32_pkg::stage_t  stage_next [0:NI];
    div32_pkg::result_t result_reg;
    div32_pkg::result_t result_next;
    logic [LAST:0]      valid_reg;
    logic [LAST:0]      advance;

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        advance[LAST] = !valid_reg[LAST] || out_ready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            advance[k] = !valid_reg[k] || advance[k + 1];
        end
    end

    assign in_ready = advance[0];

    // setup: magnitudes, signs, quotient-fits pre-check
    always_comb
    begin
        logic [31:0] dvd_mag;
        logic [15:0] dvs_mag;
        logic        is_signed;
        is_signed = (operation == div32_pkg::OP_SIGNED);
        dvd_mag   = (is_signed && dividend[31]) ? (32'd0 - dividend) : dividend;
        dvs_mag   = (is_signed && divisor[15]) ? (16'd0 - divisor) : divisor;
        stage_next[0].acc         = dvd_mag;
        stage_next[0].divisor_mag = dvs_mag;
        stage_next[0].dividend    = dividend;
        stage_next[0].signed_op   = is_signed;
        stage_next[0].q_neg       = is_signed && (dividend[31] ^ divisor[15]);
        stage_next[0].r_neg       = is_signed && dividend[31];
        // quotient below 2^16 exactly when the upper half is below the divisor
        stage_next[0].pre_ovf     = (dvd_mag[31:16] >= dvs_mag);
        stage_next[0].trap        = (divisor == 16'd0);
        stage_next[0].old_n       = old_n;
        stage_next[0].old_z       = old_z;
        stage_next[0].old_c       = old_c;
    end

    for (genvar g = 1; g <= NI; g++)
    begin : g_iter
        always_comb
        begin
            logic [31:0] acc;
            acc = stage_reg[g - 1].acc;
            for (int s = 0; s < div32_pkg::STEPS_PER_STAGE; s++)
            begin
                acc = div32_pkg::div_step(acc, stage_reg[g - 1].divisor_mag);
            end
            stage_next[g]     = stage_reg[g - 1];
            stage_next[g].acc = acc;
        end
    end

    // fix signs, final overflow test, flags
    always_comb
    begin
        logic [15:0] qm;
        logic [15:0] rm;
        logic [15:0] q;
        logic [15:0] r;
        logic        ovf;
        qm  = stage_reg[NI].acc[15:0];
        rm  = stage_reg[NI].acc[31:16];
        q   = stage_reg[NI].q_neg ? (16'd0 - qm) : qm;
        r   = stage_reg[NI].r_neg ? (16'd0 - rm) : rm;
        ovf = stage_reg[NI].pre_ovf ||
              (stage_reg[NI].signed_op &&
               (stage_reg[NI].q_neg ? (qm > div32_pkg::Q_NEG_MAX)
                                    : (qm > div32_pkg::Q_POS_MAX)));
        result_next.new_register     = stage_reg[NI].dividend;
        result_next.register_written = 1'b0;
        result_next.flag_n           = stage_reg[NI].old_n;
        result_next.flag_z           = stage_reg[NI].old_z;
        result_next.flag_v           = 1'b0;
        result_next.flag_c           = stage_reg[NI].old_c;
        result_next.divide_trap      = 1'b0;
        if (stage_reg[NI].trap)
        begin
            result_next.divide_trap = 1'b1;
        end
        else if (ovf)
        begin
            result_next.flag_v = 1'b1;
        end
        else
        begin
            result_next.new_register     = {r, q};
            result_next.register_written = 1'b1;
            result_next.flag_n           = q[15];
            result_next.flag_z           = (q == 16'd0);
            result_next.flag_c           = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (advance[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k <= LAST; k++)
            begin
                if (advance[k])
                begin
                    valid_reg[k] <= valid_reg[k - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= NI; k++)
        begin
            if (advance[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
        if (advance[LAST])
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid        = valid_reg[LAST];
    assign new_register     = result_reg.new_register;
    assign register_written = result_reg.register_written;
    assign flag_n           = result_reg.flag_n;
    assign flag_z           = result_reg.flag_z;
    assign flag_v           = result_reg.flag_v;
    assign flag_c           = result_reg.flag_c;
    assign divide_trap      = result_reg.divide_trap;

    // an empty result stage must never block the input
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output stage");

    a_written_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && register_written |-> !flag_v && !flag_c && !divide_trap)
        else $error("successful divide with V, C or trap set");

    a_written_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && register_written |->
            (flag_n == new_register[15]) && (flag_z == (new_register[15:0] == 16'd0)))
        else $error("N/Z do not match stored quotient");

    a_trap_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_trap |-> !flag_v && !register_written)
        else $error("zero divide reported with V or register write");

endmodule
